/* sv/scfr_pkg.sv */
// Shared types and constants for the serial command frame receiver.
// Used by the receiver top level and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

	// command codes and fixed header values
	localparam logic [7:0] CMD_UPLOAD   = 8'd1;
	localparam logic [7:0] CMD_RUN      = 8'd255;
	localparam logic [15:0] RUN_ACK     = 16'd3;
	localparam logic [3:0] HEADER_BYTES = 4'd9;

	// status values carried on a checksum status beat
	localparam logic [15:0] STATUS_MATCH    = 16'd0;
	localparam logic [15:0] STATUS_MISMATCH = 16'd1;

	// result queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// kind of a result beat
	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_WORD   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// one result beat
	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic [31:0] index;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

/* sv/serial_command_frame_receiver_unit.sv */
// Serial command frame receiver: header parser, payload word assembler and
// checksum check, with a small result queue on the output side.
// Depends on scfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A result beat is registered into the result queue when the byte that causes it
// is taken and offered from the queue head; a second result of the byte follows it.
// Throughput: one byte per cycle; the slave side is held off only while the
// four-entry result queue has fewer than two free slots.
// Reset (arst_n low, asynchronous): parser returns to the first header byte,
// all sums and counters clear and the result queue empties.
module serial_command_frame_receiver_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] reply_value, [47:16] word_index
	output logic [1:0]       m_tuser,   // [1:0] reply_kind
	output logic             m_tlast    // last
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'b01,
		PH_PAYLOAD = 2'b10
	} phase_t;

	// parser state
	phase_t      phase_q;
	logic [3:0]  header_count_q;
	logic [7:0]  command_code_q;
	logic [31:0] frame_length_q;
	logic [31:0] expected_sum_q;
	logic [31:0] running_sum_q;
	logic [31:0] words_done_q;
	logic [7:0]  low_byte_hold_q;
	logic        high_byte_next_q;

	phase_t      phase_n;
	logic [3:0]  header_count_n;
	logic [7:0]  command_code_n;
	logic [31:0] frame_length_n;
	logic [31:0] expected_sum_n;
	logic [31:0] running_sum_n;
	logic [31:0] words_done_n;
	logic [7:0]  low_byte_hold_n;
	logic        high_byte_next_n;

	scfr_pkg::result_t res0;
	scfr_pkg::result_t res1;
	logic [1:0]        res_cnt;

	// result queue
	scfr_pkg::result_t           queue_q [scfr_pkg::QUEUE_DEPTH];
	logic [scfr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [scfr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [scfr_pkg::QPTR_W:0]   count_q;

	logic        in_beat;
	logic        out_beat;
	logic [3:0]  hc;
	logic [3:0]  hc_inc;
	logic [1:0]  lane_len;
	logic [1:0]  lane_exp;
	logic [15:0] word;
	logic [31:0] sum_word;
	logic        final_word;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign s_tready = (count_q <= (scfr_pkg::QPTR_W+1)'(scfr_pkg::QUEUE_DEPTH - 2));

	// header byte position, wrapping a stray count back to the start
	assign hc       = (header_count_q >= scfr_pkg::HEADER_BYTES) ? 4'd0 : header_count_q;
	assign hc_inc   = hc + 4'd1;
	assign lane_len = 2'(hc - 4'd1);
	assign lane_exp = 2'(hc - 4'd5);

	// payload word assembly and running sum
	assign word       = {s_tdata, low_byte_hold_q};
	assign sum_word   = running_sum_q + {16'd0, word};
	assign final_word = ((words_done_q + 32'd1) == frame_length_q);

	// next state and results for one byte
	always_comb begin
		phase_n          = phase_q;
		header_count_n   = header_count_q;
		command_code_n   = command_code_q;
		frame_length_n   = frame_length_q;
		expected_sum_n   = expected_sum_q;
		running_sum_n    = running_sum_q;
		words_done_n     = words_done_q;
		low_byte_hold_n  = low_byte_hold_q;
		high_byte_next_n = high_byte_next_q;
		res0             = '{kind: scfr_pkg::KIND_ACK, value: 16'd0, index: 32'd0, last: 1'b1};
		res1             = '{kind: scfr_pkg::KIND_STATUS, value: 16'd0, index: 32'd0,
				last: 1'b1};
		res_cnt          = 2'd0;
		case (phase_q)
			PH_PAYLOAD: begin
				if (!high_byte_next_q) begin
					low_byte_hold_n  = s_tdata;
					high_byte_next_n = 1'b1;
				end else begin
					high_byte_next_n = 1'b0;
					running_sum_n    = sum_word;
					words_done_n     = words_done_q + 32'd1;
					res0.kind        = scfr_pkg::KIND_WORD;
					res0.value       = word;
					res0.index       = words_done_q;
					if (final_word) begin
						res0.last      = 1'b0;
						res1.value     = (sum_word == expected_sum_q) ?
								scfr_pkg::STATUS_MATCH : scfr_pkg::STATUS_MISMATCH;
						res_cnt        = 2'd2;
						phase_n        = PH_HEADER;
						header_count_n = 4'd0;
					end else begin
						res_cnt = 2'd1;
					end
				end
			end
			default: begin
				// header parsing; an unused phase code lands here too
				case (hc) inside
					4'd0: begin
						command_code_n = s_tdata;
						frame_length_n = 32'd0;
						expected_sum_n = 32'd0;
					end
					[4'd1:4'd4]: frame_length_n[{lane_len, 3'b000} +: 8] = s_tdata;
					default:     expected_sum_n[{lane_exp, 3'b000} +: 8] = s_tdata;
				endcase
				header_count_n = hc_inc;
				if (hc_inc >= scfr_pkg::HEADER_BYTES) begin
					phase_n          = PH_HEADER;
					header_count_n   = 4'd0;
					running_sum_n    = 32'd0;
					words_done_n     = 32'd0;
					high_byte_next_n = 1'b0;
					low_byte_hold_n  = 8'd0;
					if (command_code_q == scfr_pkg::CMD_RUN) begin
						res0.value = scfr_pkg::RUN_ACK;
						res_cnt    = 2'd1;
					end else if (command_code_q == scfr_pkg::CMD_UPLOAD) begin
						res0.value = frame_length_q[15:0];
						if (frame_length_q == 32'd0) begin
							res0.last  = 1'b0;
							res1.value = (expected_sum_n == 32'd0) ?
									scfr_pkg::STATUS_MATCH : scfr_pkg::STATUS_MISMATCH;
							res_cnt    = 2'd2;
						end else begin
							res_cnt = 2'd1;
							phase_n = PH_PAYLOAD;
						end
					end
				end
			end
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HEADER;
			header_count_q   <= 4'd0;
			command_code_q   <= 8'd0;
			frame_length_q   <= 32'd0;
			expected_sum_q   <= 32'd0;
			running_sum_q    <= 32'd0;
			words_done_q     <= 32'd0;
			low_byte_hold_q  <= 8'd0;
			high_byte_next_q <= 1'b0;
		end else if (in_beat) begin
			phase_q          <= phase_n;
			header_count_q   <= header_count_n;
			command_code_q   <= command_code_n;
			frame_length_q   <= frame_length_n;
			expected_sum_q   <= expected_sum_n;
			running_sum_q    <= running_sum_n;
			words_done_q     <= words_done_n;
			low_byte_hold_q  <= low_byte_hold_n;
			high_byte_next_q <= high_byte_next_n;
		end
	end

	// queue entries, up to two written per byte
	always_ff @(posedge clk) begin
		if (in_beat && (res_cnt != 2'd0))
			queue_q[wr_ptr_q] <= res0;
		if (in_beat && (res_cnt == 2'd2))
			queue_q[wr_ptr_q + 1'b1] <= res1;
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_beat)
				wr_ptr_q <= wr_ptr_q + scfr_pkg::QPTR_W'(res_cnt);
			if (out_beat)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (scfr_pkg::QPTR_W+1)'(in_beat ? res_cnt : 2'd0)
					- (scfr_pkg::QPTR_W+1)'(out_beat);
		end
	end

	// master side driven from the queue head
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {queue_q[rd_ptr_q].index, queue_q[rd_ptr_q].value};
	assign m_tuser  = queue_q[rd_ptr_q].kind;
	assign m_tlast  = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire

/* sv/scfr_checker.sv */
// Port-level checker for the serial command frame receiver, bound to the top.
// Depends on scfr_pkg and serial_command_frame_receiver_unit.
`timescale 1ns / 1ps
`default_nettype none

module scfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// a stalled result beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn while stalled");

	// a checksum status always closes the results of its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == scfr_pkg::KIND_STATUS) |-> m_tlast)
		else $error("status beat without last");

	// status carries only match or mismatch
	a_status_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == scfr_pkg::KIND_STATUS) |-> (m_tdata[15:1] == 15'd0))
		else $error("status value out of range");

	// only payload words carry an index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != scfr_pkg::KIND_WORD) |-> (m_tdata[47:16] == 32'd0))
		else $error("nonzero index on a non-word beat");

	// a beat without last is followed by its companion beat
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("second result of a byte missing");

endmodule

bind serial_command_frame_receiver_unit scfr_checker u_scfr_checker (.*);

`default_nettype wire

/* verif/tb_serial_command_frame_receiver_unit.sv */
// Self-checking testbench for serial_command_frame_receiver_unit: a queue-fed
// stream driver, a result monitor and a cycle-free predictor of the frame parser.
// Depends on scfr_pkg and the receiver top level.
`timescale 1ns / 1ps

module tb_serial_command_frame_receiver_unit;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // [15:0] reply_value, [47:16] word_index
	logic [1:0]  m_tuser;          // [1:0] reply_kind
	logic        m_tlast;

	serial_command_frame_receiver_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// byte stream waiting to be sent and replies waiting to be seen
	logic [7:0]            rx_bytes [$];
	scfr_pkg::result_t     expected_replies [$];
	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned error_count = 0;
	logic        rx_taken = 1'b0;
	bit          no_idle = 1'b0;
	int unsigned rx_gap = 0;
	int unsigned tx_stall = 0;

	// parser state mirrored by the predictor
	parse_phase_t rx_phase = PH_HEADER;
	logic [3:0]   hdr_count = 4'd0;
	logic [7:0]   hdr_cmd = 8'd0;
	logic [31:0]  hdr_length = 32'd0;
	logic [31:0]  hdr_checksum = 32'd0;
	logic [31:0]  word_sum = 32'd0;
	logic [31:0]  word_count = 32'd0;
	logic [7:0]   held_low = 8'd0;
	logic         awaiting_high = 1'b0;

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic queue_reply(input scfr_pkg::kind_t kind, input logic [15:0] value,
			input logic [31:0] index, input logic last);
		scfr_pkg::result_t r;
		r.kind = kind;
		r.value = value;
		r.index = index;
		r.last = last;
		expected_replies.push_back(r);
	endtask

	// advance the parser model by one received byte
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [15:0] word;
		if (rx_phase == PH_PAYLOAD) begin
			if (!awaiting_high) begin
				held_low = b;
				awaiting_high = 1'b1;
			end else begin
				awaiting_high = 1'b0;
				word = {b, held_low};
				word_sum = word_sum + {16'd0, word};
				if (word_count + 32'd1 == hdr_length) begin
					queue_reply(scfr_pkg::KIND_WORD, word, word_count, 1'b0);
					queue_reply(scfr_pkg::KIND_STATUS,
						(word_sum == hdr_checksum) ?
						scfr_pkg::STATUS_MATCH : scfr_pkg::STATUS_MISMATCH,
						32'd0, 1'b1);
					rx_phase = PH_HEADER;
					hdr_count = 4'd0;
				end else begin
					queue_reply(scfr_pkg::KIND_WORD, word, word_count, 1'b1);
				end
				word_count = word_count + 32'd1;
			end
		end else begin
			if (hdr_count >= scfr_pkg::HEADER_BYTES)
				hdr_count = 4'd0;
			if (hdr_count == 4'd0) begin
				hdr_cmd = b;
				hdr_length = 32'd0;
				hdr_checksum = 32'd0;
			end else if (hdr_count <= 4'd4) begin
				hdr_length[8 * (hdr_count - 4'd1) +: 8] = b;
			end else begin
				hdr_checksum[8 * (hdr_count - 4'd5) +: 8] = b;
			end
			hdr_count = hdr_count + 4'd1;
			// complete header: act on the command
			if (hdr_count == scfr_pkg::HEADER_BYTES) begin
				hdr_count = 4'd0;
				rx_phase = PH_HEADER;
				word_sum = 32'd0;
				word_count = 32'd0;
				awaiting_high = 1'b0;
				held_low = 8'd0;
				if (hdr_cmd == scfr_pkg::CMD_RUN) begin
					queue_reply(scfr_pkg::KIND_ACK, scfr_pkg::RUN_ACK, 32'd0, 1'b1);
				end else if (hdr_cmd == scfr_pkg::CMD_UPLOAD) begin
					if (hdr_length == 32'd0) begin
						queue_reply(scfr_pkg::KIND_ACK, 16'd0, 32'd0, 1'b0);
						queue_reply(scfr_pkg::KIND_STATUS,
							(hdr_checksum == 32'd0) ?
							scfr_pkg::STATUS_MATCH : scfr_pkg::STATUS_MISMATCH,
							32'd0, 1'b1);
					end else begin
						queue_reply(scfr_pkg::KIND_ACK, hdr_length[15:0], 32'd0, 1'b1);
						rx_phase = PH_PAYLOAD;
					end
				end
			end
		end
	endtask

	// stream driver: one byte beat per accepted handshake, random gaps unless no_idle is set
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !rx_taken) begin
			// beat still offered
		end else if (rx_gap > 0) begin
			rx_gap--;
			s_tvalid <= 1'b0;
		end else if (rx_bytes.size() == 0) begin
			s_tvalid <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			rx_gap = $urandom_range(1, 6) - 1;
			s_tvalid <= 1'b0;
		end else begin
			s_tvalid <= 1'b1;
			s_tdata <= rx_bytes.pop_front();
		end
	end

	// result side back-pressure in random bursts, none while no_idle is set
	always @(negedge clk) begin
		if (no_idle) begin
			m_tready <= 1'b1;
		end else if (tx_stall > 0) begin
			tx_stall--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			tx_stall = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: check result beats, predict from accepted byte beats
	always @(posedge clk) begin : watch_ports
		scfr_pkg::result_t want;
		if (!arst_n) begin
			rx_taken <= 1'b0;
		end else begin
			rx_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 48'd0);
				end else begin
					want = expected_replies.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("reply_kind", 48'(m_tuser), 48'(want.kind));
					if (m_tdata[15:0] !== want.value)
						report_mismatch("reply_value", 48'(m_tdata[15:0]),
							48'(want.value));
					if (m_tdata[47:16] !== want.index)
						report_mismatch("word_index", 48'(m_tdata[47:16]),
							48'(want.index));
					if (m_tlast !== want.last)
						report_mismatch("last", 48'(m_tlast), 48'(want.last));
				end
			end
			if (s_tvalid && s_tready) begin
				parse_rx_byte(s_tdata);
				bytes_accepted++;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_header(input logic [7:0] cmd, input logic [31:0] len,
			input logic [31:0] checksum);
		push_byte(cmd);
		for (int i = 0; i < 4; i++)
			push_byte(len[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			push_byte(checksum[8 * i +: 8]);
	endtask

	// upload frame: header then n_words little-endian payload words
	task automatic push_upload(input logic [31:0] frame_len, input int unsigned n_words,
			input bit fixed, input logic [15:0] fill, input bit corrupt);
		logic [15:0] words [$];
		logic [31:0] total;
		logic [15:0] w;
		total = 32'd0;
		for (int unsigned i = 0; i < n_words; i++) begin
			if (fixed)
				w = fill;
			else case ($urandom_range(0, 7))
				0: w = 16'h0000;
				1: w = 16'hFFFF;
				default: w = 16'($urandom_range(0, 16'hFFFF));
			endcase
			words.push_back(w);
			total = total + {16'd0, w};
		end
		push_header(scfr_pkg::CMD_UPLOAD, frame_len,
			corrupt ? (total ^ ($urandom() | 32'd1)) : total);
		foreach (words[i]) begin
			push_byte(words[i][7:0]);
			push_byte(words[i][15:8]);
		end
	endtask

	// mostly well-formed uploads, some run commands and unknown headers
	task automatic push_random_frames(input int unsigned n_bytes);
		int unsigned start;
		int unsigned len;
		logic [7:0] cmd;
		start = bytes_queued;
		while (bytes_queued - start < n_bytes) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					push_header(scfr_pkg::CMD_RUN, $urandom(), $urandom());
				end
				3, 4, 5: begin
					cmd = 8'($urandom_range(2, 254));
					if ($urandom_range(0, 7) == 0)
						cmd = 8'h00;
					push_header(cmd, $urandom(), $urandom());
				end
				default: begin
					case ($urandom_range(0, 9))
						0: len = 0;
						1: len = $urandom_range(7, 20);
						default: len = $urandom_range(1, 6);
					endcase
					push_upload(len, len, 1'b0, 16'd0, $urandom_range(0, 9) < 4);
				end
			endcase
		end
	endtask

	task automatic wait_rx_drained();
		while (bytes_accepted != bytes_queued)
			@(posedge clk);
	endtask

	task automatic wait_all_drained();
		while (bytes_accepted != bytes_queued || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	// stimulus sequence and final verdict
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames
		push_header(scfr_pkg::CMD_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_header(8'h00, 32'd0, 32'd0);
		push_header(8'hFE, 32'd1, 32'd0);
		push_upload(32'd0, 0, 1'b0, 16'd0, 1'b0);
		push_header(scfr_pkg::CMD_UPLOAD, 32'd0, 32'h8000_0000);
		push_upload(32'd1, 1, 1'b1, 16'hFFFF, 1'b0);
		push_upload(32'd2, 2, 1'b1, 16'h0000, 1'b1);
		push_upload(32'd3, 3, 1'b0, 16'd0, 1'b0);
		push_header(8'h02, 32'd5, 32'd5);
		push_header(scfr_pkg::CMD_RUN, 32'd0, 32'd0);
		wait_all_drained();

		// random frames in chunks, one full pause in the middle
		for (int chunk = 0; chunk < 5; chunk++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			push_random_frames(90);
			wait_rx_drained();
			if (chunk == 2)
				wait_all_drained();
		end

		// closing part without idling; huge length keeps the payload open
		no_idle = 1'b1;
		push_random_frames(40);
		push_upload(32'hFFFF_FFFF, 3, 1'b0, 16'd0, 1'b0);
		push_byte(8'($urandom_range(0, 255)));
		wait_all_drained();
		repeat (16) @(posedge clk);

		if (expected_replies.size() != 0)
			report_mismatch("results never arrived", 48'(expected_replies.size()), 48'd0);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
